// File: src/tree_lowest_common_ancestor_unit_macros.svh
// Assertion macros for the tree lowest common ancestor unit.
`ifndef TREE_LOWEST_COMMON_ANCESTOR_UNIT_MACROS_SVH
`define TREE_LOWEST_COMMON_ANCESTOR_UNIT_MACROS_SVH
`ifndef SYNTHESIS
// Check that a property holds at every clock edge outside reset.
`define TLCA_ASSERT(name, clk, rst, prop) \
   name: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("tlca assertion failed");
// Check that an expression is never true outside reset.
`define TLCA_NEVER(name, clk, rst, expr) \
   name: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("tlca forbidden condition seen");
`else
`define TLCA_ASSERT(name, clk, rst, prop)
`define TLCA_NEVER(name, clk, rst, expr)
`endif
`endif

// File: src/tlca_pkg.sv
// ----------------------------------------------------------------------------
// tlca_pkg
// Shared constants, codes and types of the lowest common ancestor unit.
// ----------------------------------------------------------------------------
package tlca_pkg;

   localparam int MAX_NODES   = 1024;
   localparam int NODE_W      = $clog2(MAX_NODES);
   localparam int COUNT_W     = NODE_W + 1;
   localparam int LINK_W      = NODE_W + 1;
   localparam int TIME_W      = NODE_W + 1;
   localparam int CFG_W       = 11;
   localparam int REQ_W       = 2;
   localparam int LIFT_LEVELS = 10;
   localparam int LVL_W       = (LIFT_LEVELS > 1) ? $clog2(LIFT_LEVELS) : 1;
   localparam int LIFT_AW     = LVL_W + NODE_W;
   localparam int LIFT_DEPTH  = MAX_NODES * LIFT_LEVELS;

   // empty link: top bit set, never a node number
   localparam logic [LINK_W-1:0] EMPTY_LINK = LINK_W'(MAX_NODES);

   localparam logic KIND_BUILD = 1'b0;
   localparam logic KIND_QUERY = 1'b1;

   typedef enum logic [REQ_W-1:0] {
      REQ_LOAD   = 2'd0,
      REQ_BUILD  = 2'd1,
      REQ_QUERY  = 2'd2,
      REQ_UNUSED = 2'd3
   } req_code_type;

   typedef enum logic [4:0] {
      S_IDLE, S_CLR, S_LRD, S_LCHK, S_LLINK, S_TINIT, S_TRFC, S_TCFC,
      S_TRNS, S_TCNS, S_XRD1, S_XRD2, S_XWR, S_BDONE, S_QRDU, S_QRDV,
      S_QCHK, S_QLIFT, S_QTEST, S_QFIN
   } state_type;

   typedef enum logic [4:0] {
      OP_NONE, OP_ACCEPT, OP_CLEAR, OP_LINK_READ, OP_LINK_CHECK, OP_LINK_WRITE,
      OP_TOUR_INIT, OP_CHILD_READ, OP_CHILD_CHECK, OP_SIB_READ, OP_SIB_CHECK,
      OP_LIFT_READ, OP_LIFT_CHASE, OP_LIFT_WRITE, OP_BUILD_DONE, OP_Q_READ_U,
      OP_Q_READ_V, OP_Q_CHECK, OP_Q_LIFT, OP_Q_TEST, OP_Q_FINISH
   } dp_op_type;

   typedef struct packed {
      dp_op_type op;
   } cmd_type;

   typedef struct packed {
      logic link_none;
      logic idx_last;
      logic idx_one;
      logic parent_ok;
      logic push;
      logic sibling;
      logic sp_zero;
      logic lvl_last;
      logic lvl_zero;
      logic q_early;
   } status_type;

   function automatic logic [LIFT_AW-1:0] lift_addr(input logic [LVL_W-1:0] lvl,
                                                    input logic [NODE_W-1:0] nd);
      return {lvl, nd};
   endfunction

endpackage

// File: src/tlca_ram.sv
// ----------------------------------------------------------------------------
// tlca_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module tlca_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                      clock,
   input  logic                                      wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                          wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                          rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

// File: src/tlca_ctrl.sv
// ----------------------------------------------------------------------------
// tlca_ctrl
// Sequencer for load, build (clear, link, tour, lift) and query phases.
// ----------------------------------------------------------------------------
module tlca_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic [tlca_pkg::REQ_W-1:0] req_type,
   input  tlca_pkg::status_type      status,
   output tlca_pkg::cmd_type         cmd,
   output logic                      busy
);
   import tlca_pkg::*;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               if (req_type == REQ_BUILD) begin
                  state_in = S_CLR;
               end else if (req_type == REQ_QUERY) begin
                  state_in = S_QRDU;
               end
            end
         end
         S_CLR: begin
            if (status.idx_last) begin
               state_in = status.link_none ? S_TINIT : S_LRD;
            end
         end
         S_LRD:   state_in = S_LCHK;
         S_LCHK: begin
            if (status.parent_ok) begin
               state_in = S_LLINK;
            end else begin
               state_in = status.idx_one ? S_TINIT : S_LRD;
            end
         end
         S_LLINK: state_in = status.idx_one ? S_TINIT : S_LRD;
         S_TINIT: state_in = S_TRFC;
         S_TRFC:  state_in = S_TCFC;
         S_TCFC:  state_in = status.push ? S_TRFC : S_TRNS;
         S_TRNS:  state_in = S_TCNS;
         S_TCNS: begin
            if (status.sibling) begin
               state_in = S_TRFC;
            end else if (status.sp_zero) begin
               state_in = (LIFT_LEVELS > 1) ? S_XRD1 : S_BDONE;
            end else begin
               state_in = S_TRNS;
            end
         end
         S_XRD1:  state_in = S_XRD2;
         S_XRD2:  state_in = S_XWR;
         S_XWR:   state_in = (status.idx_last && status.lvl_last) ? S_BDONE : S_XRD1;
         S_BDONE: state_in = S_IDLE;
         S_QRDU:  state_in = S_QRDV;
         S_QRDV:  state_in = S_QCHK;
         S_QCHK:  state_in = status.q_early ? S_IDLE : S_QLIFT;
         S_QLIFT: state_in = S_QTEST;
         S_QTEST: state_in = status.lvl_zero ? S_QFIN : S_QLIFT;
         S_QFIN:  state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      cmd.op = OP_NONE;
      case (state_ff)
         S_IDLE:  cmd.op = start ? OP_ACCEPT : OP_NONE;
         S_CLR:   cmd.op = OP_CLEAR;
         S_LRD:   cmd.op = OP_LINK_READ;
         S_LCHK:  cmd.op = OP_LINK_CHECK;
         S_LLINK: cmd.op = OP_LINK_WRITE;
         S_TINIT: cmd.op = OP_TOUR_INIT;
         S_TRFC:  cmd.op = OP_CHILD_READ;
         S_TCFC:  cmd.op = OP_CHILD_CHECK;
         S_TRNS:  cmd.op = OP_SIB_READ;
         S_TCNS:  cmd.op = OP_SIB_CHECK;
         S_XRD1:  cmd.op = OP_LIFT_READ;
         S_XRD2:  cmd.op = OP_LIFT_CHASE;
         S_XWR:   cmd.op = OP_LIFT_WRITE;
         S_BDONE: cmd.op = OP_BUILD_DONE;
         S_QRDU:  cmd.op = OP_Q_READ_U;
         S_QRDV:  cmd.op = OP_Q_READ_V;
         S_QCHK:  cmd.op = OP_Q_CHECK;
         S_QLIFT: cmd.op = OP_Q_LIFT;
         S_QTEST: cmd.op = OP_Q_TEST;
         S_QFIN:  cmd.op = OP_Q_FINISH;
         default: cmd.op = OP_NONE;
      endcase
   end

   assign busy = (state_ff != S_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end
endmodule

// File: src/tlca_dp.sv
// ----------------------------------------------------------------------------
// tlca_dp
// Tables, tour registers, query registers and the result register.
// ----------------------------------------------------------------------------
module tlca_dp (
   input  logic                       clock,
   input  logic                       reset,
   input  tlca_pkg::cmd_type          cmd,
   output tlca_pkg::status_type       status,
   input  logic [tlca_pkg::REQ_W-1:0]  req_type,
   input  logic [tlca_pkg::NODE_W-1:0] req_node,
   input  logic [tlca_pkg::NODE_W-1:0] req_other_node,
   input  logic                       csr_wr_en,
   input  logic [tlca_pkg::CFG_W-1:0]  csr_wr_data,
   output logic                       rsp_strobe,
   output logic                       rsp_result_kind,
   output logic [tlca_pkg::NODE_W-1:0] rsp_ancestor
);
   import tlca_pkg::*;

   logic [CFG_W-1:0]   count_ff, count_in;
   logic [COUNT_W-1:0] idx_ff, idx_in;
   logic [LVL_W-1:0]   level_ff, level_in;
   logic [NODE_W-1:0]  cur_ff, cur_in;
   logic [COUNT_W-1:0] sp_ff, sp_in;
   logic [TIME_W-1:0]  clk_ff, clk_in;
   logic [NODE_W-1:0]  par_ff, par_in;
   logic [NODE_W-1:0]  w_ff, w_in;
   logic [NODE_W-1:0]  qu_ff, qu_in;
   logic [NODE_W-1:0]  qv_ff, qv_in;
   logic [TIME_W-1:0]  eu_ff, eu_in, xu_ff, xu_in, ev_ff, ev_in, xv_ff, xv_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_kind_ff, rsp_kind_in;
   logic [NODE_W-1:0]  rsp_anc_ff, rsp_anc_in;

   logic [COUNT_W-1:0] cnt_n;
   logic [COUNT_W-1:0] sp_dec;
   logic [NODE_W-1:0]  early_ans;
   logic               q_anc_w;
   logic [NODE_W-1:0]  u_next;
   logic [LVL_W-1:0]   lvl_dec;

   // memory ports
   logic               par_we;
   logic [NODE_W-1:0]  par_wa, par_ra, par_rd;
   logic [NODE_W-1:0]  par_wd;
   logic               fc_we;
   logic [NODE_W-1:0]  fc_wa, fc_ra;
   logic [LINK_W-1:0]  fc_wd, fc_rd;
   logic               ns_we;
   logic [NODE_W-1:0]  ns_wa, ns_ra;
   logic [LINK_W-1:0]  ns_wd, ns_rd;
   logic               en_we;
   logic [NODE_W-1:0]  en_wa, en_ra;
   logic [TIME_W-1:0]  en_wd, en_rd;
   logic               ex_we;
   logic [NODE_W-1:0]  ex_wa, ex_ra;
   logic [TIME_W-1:0]  ex_wd, ex_rd;
   logic               st_we;
   logic [NODE_W-1:0]  st_wa, st_ra, st_wd, st_rd;
   logic               lf_we;
   logic [LIFT_AW-1:0] lf_wa, lf_ra;
   logic [NODE_W-1:0]  lf_wd, lf_rd;

   always_comb begin
      if (count_ff >= CFG_W'(MAX_NODES)) begin
         cnt_n = COUNT_W'(MAX_NODES);
      end else if (count_ff == '0) begin
         cnt_n = COUNT_W'(1);
      end else begin
         cnt_n = COUNT_W'(count_ff);
      end
   end

   assign sp_dec  = sp_ff - 1'b1;
   assign lvl_dec = level_ff - 1'b1;

   // status toward the controller
   always_comb begin
      status.link_none = (cnt_n < COUNT_W'(2));
      status.idx_last  = (idx_ff == COUNT_W'(MAX_NODES - 1));
      status.idx_one   = (idx_ff == COUNT_W'(1));
      status.parent_ok = ({1'b0, par_rd} < cnt_n);
      status.push      = !fc_rd[LINK_W-1] && (sp_ff < COUNT_W'(MAX_NODES));
      status.sibling   = !ns_rd[LINK_W-1] && (sp_ff != '0);
      status.sp_zero   = (sp_ff == '0);
      status.lvl_last  = (level_ff == LVL_W'(LIFT_LEVELS - 1));
      status.lvl_zero  = (level_ff == '0);
      status.q_early   = 1'b1;
      early_ans        = '0;
      if (({1'b0, qu_ff} >= cnt_n) || ({1'b0, qv_ff} >= cnt_n)) begin
         early_ans = '0;
      end else if ((xu_ff == '0) || (ex_rd == '0)) begin
         early_ans = '0;
      end else if ((eu_ff <= en_rd) && (xu_ff >= ex_rd)) begin
         early_ans = qu_ff;
      end else if ((en_rd <= eu_ff) && (ex_rd >= xu_ff)) begin
         early_ans = qv_ff;
      end else begin
         status.q_early = 1'b0;
      end
   end

   // lift step: keep the jump only when it does not reach an ancestor of v
   assign q_anc_w = (en_rd <= ev_ff) && (ex_rd >= xv_ff);
   assign u_next  = q_anc_w ? qu_ff : w_ff;

   // memory control
   always_comb begin
      par_we = (cmd.op == OP_ACCEPT) && (req_type == REQ_LOAD) && (req_node != '0);
      par_wa = req_node;
      par_wd = req_other_node;
      par_ra = idx_ff[NODE_W-1:0];

      fc_we = 1'b0;
      fc_wa = idx_ff[NODE_W-1:0];
      fc_wd = EMPTY_LINK;
      fc_ra = cur_ff;
      ns_we = 1'b0;
      ns_wa = idx_ff[NODE_W-1:0];
      ns_wd = EMPTY_LINK;
      ns_ra = cur_ff;
      en_we = 1'b0;
      en_wa = idx_ff[NODE_W-1:0];
      en_wd = '0;
      en_ra = qu_ff;
      ex_we = 1'b0;
      ex_wa = idx_ff[NODE_W-1:0];
      ex_wd = '0;
      ex_ra = qu_ff;
      st_we = 1'b0;
      st_wa = sp_ff[NODE_W-1:0];
      st_wd = cur_ff;
      st_ra = sp_dec[NODE_W-1:0];
      lf_we = 1'b0;
      lf_wa = lift_addr('0, idx_ff[NODE_W-1:0]);
      lf_wd = '0;
      lf_ra = lift_addr(lvl_dec, idx_ff[NODE_W-1:0]);

      case (cmd.op)
         OP_CLEAR: begin
            fc_we = 1'b1;
            ns_we = 1'b1;
            en_we = 1'b1;
            ex_we = 1'b1;
            lf_we = 1'b1;
         end
         OP_LINK_CHECK: begin
            fc_ra = par_rd;
         end
         OP_LINK_WRITE: begin
            // prepend node to its parent's child list
            ns_we = 1'b1;
            ns_wd = fc_rd;
            fc_we = 1'b1;
            fc_wa = par_ff;
            fc_wd = LINK_W'(idx_ff);
         end
         OP_TOUR_INIT: begin
            en_we = 1'b1;
            en_wa = '0;
            en_wd = '0;
         end
         OP_CHILD_CHECK: begin
            if (status.push) begin
               st_we = 1'b1;
               lf_we = 1'b1;
               lf_wa = lift_addr('0, fc_rd[NODE_W-1:0]);
               lf_wd = cur_ff;
               en_we = 1'b1;
               en_wa = fc_rd[NODE_W-1:0];
               en_wd = clk_ff;
            end else begin
               ex_we = 1'b1;
               ex_wa = cur_ff;
               ex_wd = clk_ff;
            end
         end
         OP_SIB_CHECK: begin
            if (status.sibling) begin
               lf_we = 1'b1;
               lf_wa = lift_addr('0, ns_rd[NODE_W-1:0]);
               lf_wd = st_rd;
               en_we = 1'b1;
               en_wa = ns_rd[NODE_W-1:0];
               en_wd = clk_ff;
            end else if (!status.sp_zero) begin
               ex_we = 1'b1;
               ex_wa = st_rd;
               ex_wd = clk_ff;
            end
         end
         OP_LIFT_CHASE: begin
            lf_ra = lift_addr(lvl_dec, lf_rd);
         end
         OP_LIFT_WRITE: begin
            lf_we = 1'b1;
            lf_wa = lift_addr(level_ff, idx_ff[NODE_W-1:0]);
            lf_wd = lf_rd;
         end
         OP_Q_READ_V: begin
            en_ra = qv_ff;
            ex_ra = qv_ff;
         end
         OP_Q_CHECK: begin
            lf_ra = lift_addr(LVL_W'(LIFT_LEVELS - 1), qu_ff);
         end
         OP_Q_LIFT: begin
            en_ra = lf_rd;
            ex_ra = lf_rd;
         end
         OP_Q_TEST: begin
            lf_ra = lift_addr(status.lvl_zero ? '0 : lvl_dec, u_next);
         end
         default: begin
         end
      endcase
   end

   // register next values
   always_comb begin
      count_in     = csr_wr_en ? csr_wr_data : count_ff;
      idx_in       = idx_ff;
      level_in     = level_ff;
      cur_in       = cur_ff;
      sp_in        = sp_ff;
      clk_in       = clk_ff;
      par_in       = par_ff;
      w_in         = w_ff;
      qu_in        = qu_ff;
      qv_in        = qv_ff;
      eu_in        = eu_ff;
      xu_in        = xu_ff;
      ev_in        = ev_ff;
      xv_in        = xv_ff;
      rsp_valid_in = 1'b0;
      rsp_kind_in  = rsp_kind_ff;
      rsp_anc_in   = rsp_anc_ff;
      case (cmd.op)
         OP_ACCEPT: begin
            idx_in = '0;
            qu_in  = req_node;
            qv_in  = req_other_node;
         end
         OP_CLEAR: begin
            idx_in = status.idx_last ? (cnt_n - 1'b1) : (idx_ff + 1'b1);
         end
         OP_LINK_CHECK: begin
            par_in = par_rd;
            if (!status.parent_ok) begin
               idx_in = idx_ff - 1'b1;
            end
         end
         OP_LINK_WRITE: begin
            idx_in = idx_ff - 1'b1;
         end
         OP_TOUR_INIT: begin
            cur_in = '0;
            sp_in  = '0;
            clk_in = TIME_W'(1);
         end
         OP_CHILD_CHECK: begin
            clk_in = clk_ff + 1'b1;
            if (status.push) begin
               cur_in = fc_rd[NODE_W-1:0];
               sp_in  = sp_ff + 1'b1;
            end
         end
         OP_SIB_CHECK: begin
            if (status.sibling) begin
               cur_in = ns_rd[NODE_W-1:0];
               clk_in = clk_ff + 1'b1;
            end else if (!status.sp_zero) begin
               cur_in = st_rd;
               sp_in  = sp_dec;
               clk_in = clk_ff + 1'b1;
            end else begin
               idx_in   = '0;
               level_in = LVL_W'(1);
            end
         end
         OP_LIFT_WRITE: begin
            if (status.idx_last) begin
               idx_in   = '0;
               level_in = level_ff + 1'b1;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         OP_BUILD_DONE: begin
            rsp_valid_in = 1'b1;
            rsp_kind_in  = KIND_BUILD;
            rsp_anc_in   = '0;
         end
         OP_Q_READ_V: begin
            eu_in = en_rd;
            xu_in = ex_rd;
         end
         OP_Q_CHECK: begin
            ev_in    = en_rd;
            xv_in    = ex_rd;
            level_in = LVL_W'(LIFT_LEVELS - 1);
            if (status.q_early) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = KIND_QUERY;
               rsp_anc_in   = early_ans;
            end
         end
         OP_Q_LIFT: begin
            w_in = lf_rd;
         end
         OP_Q_TEST: begin
            qu_in = u_next;
            if (!status.lvl_zero) begin
               level_in = lvl_dec;
            end
         end
         OP_Q_FINISH: begin
            rsp_valid_in = 1'b1;
            rsp_kind_in  = KIND_QUERY;
            rsp_anc_in   = lf_rd;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= CFG_W'(1);
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      idx_ff      <= idx_in;
      level_ff    <= level_in;
      cur_ff      <= cur_in;
      sp_ff       <= sp_in;
      clk_ff      <= clk_in;
      par_ff      <= par_in;
      w_ff        <= w_in;
      qu_ff       <= qu_in;
      qv_ff       <= qv_in;
      eu_ff       <= eu_in;
      xu_ff       <= xu_in;
      ev_ff       <= ev_in;
      xv_ff       <= xv_in;
      rsp_kind_ff <= rsp_kind_in;
      rsp_anc_ff  <= rsp_anc_in;
   end

   assign rsp_strobe      = rsp_valid_ff;
   assign rsp_result_kind = rsp_kind_ff;
   assign rsp_ancestor    = rsp_anc_ff;

   tlca_ram #(.WIDTH(NODE_W), .DEPTH(MAX_NODES)) u_parent (
      .clock(clock), .wr_en(par_we), .wr_addr(par_wa), .wr_data(par_wd),
      .rd_addr(par_ra), .rd_data(par_rd)
   );
   tlca_ram #(.WIDTH(LINK_W), .DEPTH(MAX_NODES)) u_first_child (
      .clock(clock), .wr_en(fc_we), .wr_addr(fc_wa), .wr_data(fc_wd),
      .rd_addr(fc_ra), .rd_data(fc_rd)
   );
   tlca_ram #(.WIDTH(LINK_W), .DEPTH(MAX_NODES)) u_next_sibling (
      .clock(clock), .wr_en(ns_we), .wr_addr(ns_wa), .wr_data(ns_wd),
      .rd_addr(ns_ra), .rd_data(ns_rd)
   );
   tlca_ram #(.WIDTH(TIME_W), .DEPTH(MAX_NODES)) u_entry_time (
      .clock(clock), .wr_en(en_we), .wr_addr(en_wa), .wr_data(en_wd),
      .rd_addr(en_ra), .rd_data(en_rd)
   );
   tlca_ram #(.WIDTH(TIME_W), .DEPTH(MAX_NODES)) u_exit_time (
      .clock(clock), .wr_en(ex_we), .wr_addr(ex_wa), .wr_data(ex_wd),
      .rd_addr(ex_ra), .rd_data(ex_rd)
   );
   tlca_ram #(.WIDTH(NODE_W), .DEPTH(MAX_NODES)) u_tour_stack (
      .clock(clock), .wr_en(st_we), .wr_addr(st_wa), .wr_data(st_wd),
      .rd_addr(st_ra), .rd_data(st_rd)
   );
   tlca_ram #(.WIDTH(NODE_W), .DEPTH(LIFT_DEPTH)) u_lift (
      .clock(clock), .wr_en(lf_we), .wr_addr(lf_wa), .wr_data(lf_wd),
      .rd_addr(lf_ra), .rd_data(lf_rd)
   );
endmodule

// File: src/tree_lowest_common_ancestor_unit.sv
// ----------------------------------------------------------------------------
// tree_lowest_common_ancestor_unit
// Rooted tree store with binary-lifting lowest common ancestor queries.
// ----------------------------------------------------------------------------
// Usage: raise start with req_type, req_node and req_other_node; the request
// is taken at a clock edge where start is high and busy is low.
//   Load (parent of a node): busy never rises, no result.
//   Build: clears the link, time and base lift tables, links each node whose
//   parent is in use into the parent's child list, runs the depth-first tour,
//   fills the upper lift levels (a read, a chase and a write per entry, 9
//   levels of 1024 entries) and strobes one result with kind 0. The lift
//   fill on the lift memory's single read port dominates the build time.
//   Query: answers early when one node is the other's ancestor or either
//   node is out of use, else a lift and a test step per lift level, set by
//   the one read port of the lift memory and the entry/exit time memories.
// Results appear on rsp_* for exactly one cycle with rsp_strobe high; the
// receiver cannot stall them. csr_wr_en writes node_count; the user must
// write it only while idle, the block does not enforce it. Reset returns the
// sequencer to idle and node_count to 1; the tables keep no reset value and
// are valid after the first build.
module tree_lowest_common_ancestor_unit (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  logic [tlca_pkg::REQ_W-1:0]  req_type,
   input  logic [tlca_pkg::NODE_W-1:0] req_node,
   input  logic [tlca_pkg::NODE_W-1:0] req_other_node,
   output logic                       rsp_strobe,
   output logic                       rsp_result_kind,
   output logic [tlca_pkg::NODE_W-1:0] rsp_ancestor,
   input  logic                       csr_wr_en,
   input  logic [tlca_pkg::CFG_W-1:0]  csr_wr_data
);
   import tlca_pkg::*;
`include "tree_lowest_common_ancestor_unit_macros.svh"

   cmd_type    cmd;
   status_type status;

   tlca_ctrl u_ctrl (
      .clock(clock), .reset(reset), .start(start), .req_type(req_type),
      .status(status), .cmd(cmd), .busy(busy)
   );

   tlca_dp u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .status(status),
      .req_type(req_type), .req_node(req_node), .req_other_node(req_other_node),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data),
      .rsp_strobe(rsp_strobe), .rsp_result_kind(rsp_result_kind),
      .rsp_ancestor(rsp_ancestor)
   );

   `TLCA_NEVER(a_strobe_idle, clock, reset, rsp_strobe && busy)
   `TLCA_ASSERT(a_strobe_single, clock, reset, rsp_strobe |=> !rsp_strobe)
   `TLCA_ASSERT(a_build_busy, clock, reset,
      (start && !busy && (req_type == REQ_BUILD)) |=> busy)
   `TLCA_ASSERT(a_load_quiet, clock, reset,
      (start && !busy && (req_type == REQ_LOAD)) |=> (!busy && !rsp_strobe))
endmodule

// File: verif/testbench.sv
// ----------------------------------------------------------------------------
// Lowest common ancestor unit testbench
// Loads parent links, builds the ancestor tables and checks every query answer
// and build report against a cycle-free predictor kept inside this module.
// Trees range from a single node to 180 nodes, with deep chains, dangling
// parents, cycles and count changes after a build, including past the limit.
// ----------------------------------------------------------------------------
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import tlca_pkg::*;

   typedef struct {
      logic             kind;
      logic [NODE_W-1:0] ancestor;
   } answer_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                start = 1'b0;
   logic                busy;
   logic [REQ_W-1:0]    req_type = REQ_LOAD;
   logic [NODE_W-1:0]   req_node = '0;
   logic [NODE_W-1:0]   req_other_node = '0;
   logic                rsp_strobe;
   logic                rsp_result_kind;
   logic [NODE_W-1:0]   rsp_ancestor;
   logic                csr_wr_en = 1'b0;
   logic [CFG_W-1:0]    csr_wr_data = '0;

   answer_type answers_due[$];
   int  failures = 0;
   int  builds_seen = 0;
   int  queries_seen = 0;
   bit  steady = 1'b0;

   // shadow tree state
   logic [CFG_W-1:0]  node_limit = 1;
   logic [NODE_W-1:0] parent_link[MAX_NODES];
   int                child_head[MAX_NODES];
   int                sibling_link[MAX_NODES];
   int                jump[MAX_NODES][LIFT_LEVELS];
   int                t_in[MAX_NODES];
   int                t_out[MAX_NODES];
   int                walk_stack[MAX_NODES];

   tree_lowest_common_ancestor_unit dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_type(req_type), .req_node(req_node), .req_other_node(req_other_node),
      .rsp_strobe(rsp_strobe), .rsp_result_kind(rsp_result_kind),
      .rsp_ancestor(rsp_ancestor),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data)
   );

   always #5 clock = ~clock;

   function automatic int live_nodes();
      int n;
      n = node_limit;
      if (n > MAX_NODES) n = MAX_NODES;
      if (n == 0) n = 1;
      return n;
   endfunction

   function automatic bit covers(int a, int b);
      return t_in[a] <= t_in[b] && t_out[a] >= t_out[b];
   endfunction

   function automatic void rebuild_ancestry();
      int n, sp, cur, c, s, tick;
      bit done;
      n = live_nodes();
      sp = 0;
      cur = 0;
      done = 0;
      for (int i = 0; i < MAX_NODES; i++) begin
         child_head[i] = -1;
         sibling_link[i] = -1;
         t_in[i] = 0;
         t_out[i] = 0;
         for (int k = 0; k < LIFT_LEVELS; k++) jump[i][k] = 0;
      end
      // link in descending order so each child list runs ascending
      for (int i = n - 1; i >= 1; i--) begin
         if (parent_link[i] < n) begin
            sibling_link[i] = child_head[parent_link[i]];
            child_head[parent_link[i]] = i;
         end
      end
      tick = 0;
      t_in[0] = tick;
      tick++;
      while (!done) begin
         c = child_head[cur];
         if (c != -1 && sp < MAX_NODES) begin
            walk_stack[sp] = cur;
            sp++;
            jump[c][0] = cur;
            cur = c;
            t_in[cur] = tick;
            tick++;
         end else begin
            t_out[cur] = tick;
            tick++;
            forever begin
               s = sibling_link[cur];
               if (s != -1 && sp > 0) begin
                  jump[s][0] = walk_stack[sp - 1];
                  cur = s;
                  t_in[cur] = tick;
                  tick++;
                  break;
               end
               if (sp == 0) begin
                  done = 1;
                  break;
               end
               sp--;
               cur = walk_stack[sp];
               t_out[cur] = tick;
               tick++;
            end
         end
      end
      for (int k = 1; k < LIFT_LEVELS; k++)
         for (int i = 0; i < MAX_NODES; i++)
            jump[i][k] = jump[jump[i][k - 1]][k - 1];
   endfunction

   function automatic logic [NODE_W-1:0] common_ancestor(int u, int v);
      int n, w;
      n = live_nodes();
      if (u >= n || v >= n) return '0;
      if (t_out[u] == 0 || t_out[v] == 0) return '0;
      if (covers(u, v)) return NODE_W'(u);
      if (covers(v, u)) return NODE_W'(v);
      for (int k = LIFT_LEVELS - 1; k >= 0; k--) begin
         w = jump[u][k];
         if (!covers(w, v)) u = w;
      end
      return NODE_W'(jump[u][0]);
   endfunction

   // compare each strobed result with the oldest pending answer
   always @(posedge clock) begin
      answer_type due;
      if (!reset && rsp_strobe) begin
         if (answers_due.size() == 0) begin
            $error("unexpected result: kind %0d ancestor %0d", rsp_result_kind, rsp_ancestor);
            failures++;
         end else begin
            due = answers_due.pop_front();
            if (rsp_result_kind !== due.kind) begin
               $error("result_kind: expected %0d, got %0d", due.kind, rsp_result_kind);
               failures++;
            end
            if (rsp_ancestor !== due.ancestor) begin
               $error("ancestor: expected %0d, got %0d", due.ancestor, rsp_ancestor);
               failures++;
            end
         end
      end
   end

   task automatic send_request(req_code_type code, int a, int b);
      answer_type ans;
      req_type <= code;
      req_node <= NODE_W'(a);
      req_other_node <= NODE_W'(b);
      start <= 1'b1;
      do @(posedge clock); while (busy);
      case (code)
         REQ_LOAD: begin
            if (a != 0) parent_link[a] = NODE_W'(b);
         end
         REQ_BUILD: begin
            rebuild_ancestry();
            ans.kind = KIND_BUILD;
            ans.ancestor = '0;
            answers_due.insert(answers_due.size(), ans);
            builds_seen++;
         end
         REQ_QUERY: begin
            ans.kind = KIND_QUERY;
            ans.ancestor = common_ancestor(a, b);
            answers_due.insert(answers_due.size(), ans);
            queries_seen++;
         end
         default: ;
      endcase
      // random sender gap
      if (!steady && $urandom_range(0, 3) == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 14)) @(posedge clock);
      end
   endtask

   task automatic drain();
      start <= 1'b0;
      while (answers_due.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic write_count(int value);
      drain();
      csr_wr_en <= 1'b1;
      csr_wr_data <= CFG_W'(value);
      @(posedge clock);
      csr_wr_en <= 1'b0;
      node_limit = CFG_W'(value);
   endtask

   // parents: mostly a proper tree, some dangling or forward links
   task automatic load_tree(int n, int chain_pct);
      int p, r;
      for (int i = 1; i < n; i++) begin
         r = $urandom_range(0, 99);
         if (r < chain_pct) p = i - 1;
         else if (r < 88) p = $urandom_range(0, i - 1);
         else if (r < 94) p = $urandom_range(0, MAX_NODES - 1);
         else p = $urandom_range(i, n - 1);
         send_request(REQ_LOAD, i, p);
      end
   endtask

   task automatic random_queries(int count, int n);
      for (int j = 0; j < count; j++) begin
         if ($urandom_range(0, 9) < 8)
            send_request(REQ_QUERY, $urandom_range(0, n - 1), $urandom_range(0, n - 1));
         else
            send_request(REQ_QUERY, $urandom_range(0, MAX_NODES - 1),
                         $urandom_range(0, MAX_NODES - 1));
      end
   endtask

   task automatic test_single_node();
      write_count(0);
      send_request(REQ_LOAD, 0, 5);
      send_request(REQ_UNUSED, 1023, 1023);
      send_request(REQ_BUILD, 0, 0);
      send_request(REQ_QUERY, 0, 0);
      send_request(REQ_QUERY, 0, 1023);
      send_request(REQ_QUERY, 1023, 1023);
   endtask

   task automatic test_two_nodes();
      write_count(2);
      send_request(REQ_LOAD, 1, 0);
      send_request(REQ_LOAD, 1023, 1023);
      send_request(REQ_BUILD, 1023, 1023);
      send_request(REQ_QUERY, 1, 1);
      send_request(REQ_QUERY, 0, 1);
      send_request(REQ_QUERY, 1, 0);
      send_request(REQ_QUERY, 1, 2);
   endtask

   task automatic test_random_trees();
      int n;
      for (int round = 0; round < 4; round++) begin
         n = $urandom_range(3, 40);
         write_count(n);
         load_tree(n, round * 20);
         send_request(REQ_LOAD, $urandom_range(n, MAX_NODES - 1), $urandom_range(0, 1023));
         send_request(REQ_UNUSED, $urandom_range(0, 1023), $urandom_range(0, 1023));
         send_request(REQ_BUILD, $urandom_range(0, 1023), $urandom_range(0, 1023));
         random_queries(25, n);
      end
   endtask

   task automatic test_large_tree();
      int n;
      n = 180;
      write_count(n);
      load_tree(n, 60);
      send_request(REQ_BUILD, 0, 0);
      random_queries(20, n);
      // hold the tables across count changes, including one past the limit
      write_count(2047);
      random_queries(10, 256);
      write_count(5);
      random_queries(10, 8);
      write_count(n);
      steady = 1'b1;
      random_queries(20, n);
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_single_node();
      test_two_nodes();
      test_random_trees();
      test_large_tree();
      drain();
      $display("covered %0d builds and %0d ancestor queries, tree sizes 1 to 180,",
               builds_seen, queries_seen);
      $display("with node count changes after a build and a count above the limit");
      if (failures == 0) begin
         $display("testbench OK");
      end else begin
         $display("testbench NOT OK");
      end
      $finish;
   end

   initial begin
      #20ms;
      $display("testbench NOT OK");
      $finish;
   end
endmodule

// File: sim.f
+incdir+src
src/tlca_pkg.sv
src/tlca_ram.sv
src/tlca_ctrl.sv
src/tlca_dp.sv
src/tree_lowest_common_ancestor_unit.sv
verif/testbench.sv
